### src/ltrt_pkg.sv
// Shared types and constants for the lap time ranking table.
// Depends on nothing; every module of the block imports it.
package ltrt_pkg;

	localparam int TIME_W          = 24;
	localparam int CNT_OUT_W       = 7;
	localparam int MIN_W           = 9;
	localparam int SEC_W           = 6;
	localparam int REM_W           = 16;
	localparam int MS_PER_MINUTE   = 60000;
	localparam int MS_PER_SECOND   = 1000;
	localparam int TABLE_DEPTH_DEF = 64;

	typedef enum logic [2:0] {
		I_IDLE,
		I_READ,
		I_CMP,
		I_WRITE,
		I_DONE
	} ins_state_t;

	typedef enum logic [2:0] {
		T_IDLE,
		T_INSERT,
		T_LAUNCH,
		T_WAIT,
		T_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		OP_MEAN,
		OP_BEST_MIN,
		OP_BEST_SEC,
		OP_MEAN_MIN,
		OP_MEAN_SEC
	} div_op_t;

	typedef struct packed {
		logic done;
		logic accepted;
		logic dropped;
	} ins_stat_t;

endpackage

### src/lap_time_ranking_table_core.sv
// Top level of the lap time ranking table: command port, sequencer, result registers.
// Depends on ltrt_pkg, ltrt_insert and ltrt_div.
//
// Pulse start with a lap time in lap_ms while busy is low; the beat is taken on
// that edge and busy rises on the next cycle. A nonzero time is placed in order
// into a table of TABLE_DEPTH entries held in a single-port-per-direction memory;
// a zero time is a query. When the table is full, the time is dropped and
// dropped_full is set. Every command ends with one result beat: strobe is high
// for exactly one cycle and the receiver cannot stall it, so capture the result
// ports on that cycle. A command first runs the insertion walk, which a query
// or a dropped time skips; otherwise the walk compares m stored times (k + 1,
// with k the number of stored times larger than the new one, or just k when the
// new time lands in the first slot); each comparison is a memory read and a
// compare, and a larger stored time is moved one slot up. The sum has the width
// S = 24 + ceil(log2(TABLE_DEPTH)). The mean and the four minute and second
// splits then all go one after another through one shared restoring divider,
// one quotient bit per cycle, and the command ends with the result beat. Empty
// tables and unfilled ranks read as zero; entry_count carries the low seven bits
// of the count.
module lap_time_ranking_table_core
	import ltrt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [TIME_W-1:0]    lap_ms,
	output logic                 busy,
	output logic                 strobe,
	output logic                 accepted,
	output logic                 dropped_full,
	output logic [CNT_OUT_W-1:0] entry_count,
	output logic [TIME_W-1:0]    best_ms,
	output logic [MIN_W-1:0]     best_minutes,
	output logic [SEC_W-1:0]     best_seconds,
	output logic [TIME_W-1:0]    mean_ms,
	output logic [MIN_W-1:0]     mean_minutes,
	output logic [SEC_W-1:0]     mean_seconds,
	output logic [TIME_W-1:0]    second_ms,
	output logic [TIME_W-1:0]    third_ms
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int SUM_W = TIME_W + $clog2(TABLE_DEPTH);
	localparam int DW    = SUM_W;
	localparam int VW    = (CNT_W > REM_W) ? CNT_W : REM_W;

	top_state_t state_q, state_d;
	div_op_t    op_q;

	// insertion side
	ins_stat_t         ins_stat;
	logic              ins_start;
	logic [CNT_W-1:0]  count;
	logic [SUM_W-1:0]  sum;
	logic [TIME_W-1:0] rank0, rank1, rank2;

	// shared divider
	logic          div_start;
	logic [DW-1:0] div_dividend;
	logic [VW-1:0] div_divisor;
	logic          div_done;
	logic [DW-1:0] div_quot;
	logic [VW-1:0] div_rem;

	// result registers
	logic                 acc_q, drop_q;
	logic [CNT_OUT_W-1:0] count_q;
	logic [TIME_W-1:0]    best_q, second_q, third_q, mean_q;
	logic [MIN_W-1:0]     bmin_q, mmin_q;
	logic [SEC_W-1:0]     bsec_q, msec_q;
	logic [REM_W-1:0]     rem_q;

	logic [CNT_W+CNT_OUT_W-1:0] count_ext;

	assign count_ext = {{CNT_OUT_W{1'b0}}, count};
	assign ins_start = state_q == T_IDLE && start;

	ltrt_insert #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W)
	) u_insert (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ins_start),
		.lap_ms (lap_ms),
		.stat   (ins_stat),
		.count  (count),
		.sum    (sum),
		.rank0  (rank0),
		.rank1  (rank1),
		.rank2  (rank2)
	);

	ltrt_div #(
		.DW (DW),
		.VW (VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// next state: insert, then run the five divisions back to back, then report
	always_comb begin
		state_d = state_q;
		case (state_q)
			T_IDLE:   if (start) state_d = T_INSERT;
			T_INSERT: if (ins_stat.done) state_d = T_LAUNCH;
			T_LAUNCH: state_d = T_WAIT;
			T_WAIT: begin
				if (div_done)
					state_d = (op_q == OP_MEAN_SEC) ? T_OUT : T_LAUNCH;
			end
			T_OUT:    state_d = T_IDLE;
			default:  state_d = T_IDLE;
		endcase
	end

	// outputs of the sequencer and the divider operand select
	always_comb begin
		busy         = state_q != T_IDLE;
		strobe       = state_q == T_OUT;
		div_start    = state_q == T_LAUNCH;
		div_dividend = DW'(sum);
		div_divisor  = VW'(count);
		case (op_q)
			OP_MEAN: begin
				div_dividend = DW'(sum);
				div_divisor  = VW'(count);
			end
			OP_BEST_MIN: begin
				div_dividend = DW'(best_q);
				div_divisor  = VW'(MS_PER_MINUTE);
			end
			OP_MEAN_MIN: begin
				div_dividend = DW'(mean_q);
				div_divisor  = VW'(MS_PER_MINUTE);
			end
			OP_BEST_SEC, OP_MEAN_SEC: begin
				div_dividend = DW'(rem_q);
				div_divisor  = VW'(MS_PER_SECOND);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			op_q    <= OP_MEAN;
		end else begin
			state_q <= state_d;
			if (state_q == T_INSERT && ins_stat.done) begin
				op_q <= OP_MEAN;
			end else if (state_q == T_WAIT && div_done) begin
				case (op_q)
					OP_MEAN:     op_q <= OP_BEST_MIN;
					OP_BEST_MIN: op_q <= OP_BEST_SEC;
					OP_BEST_SEC: op_q <= OP_MEAN_MIN;
					OP_MEAN_MIN: op_q <= OP_MEAN_SEC;
					default:     op_q <= OP_MEAN;
				endcase
			end
		end
	end

	// capture the table snapshot after insertion, then each quotient as it lands
	always_ff @(posedge clk) begin
		if (state_q == T_INSERT && ins_stat.done) begin
			acc_q    <= ins_stat.accepted;
			drop_q   <= ins_stat.dropped;
			count_q  <= count_ext[CNT_OUT_W-1:0];
			best_q   <= rank0;
			second_q <= rank1;
			third_q  <= rank2;
		end
		if (state_q == T_WAIT && div_done) begin
			case (op_q)
				OP_MEAN: begin
					// empty table: hold the mean at zero, divisor was zero
					mean_q <= (count == '0) ? '0 : div_quot[TIME_W-1:0];
				end
				OP_BEST_MIN, OP_MEAN_MIN: begin
					if (op_q == OP_BEST_MIN)
						bmin_q <= div_quot[MIN_W-1:0];
					else
						mmin_q <= div_quot[MIN_W-1:0];
					rem_q <= div_rem[REM_W-1:0];
				end
				OP_BEST_SEC: bsec_q <= div_quot[SEC_W-1:0];
				OP_MEAN_SEC: msec_q <= div_quot[SEC_W-1:0];
				default: ;
			endcase
		end
	end

	assign accepted     = acc_q;
	assign dropped_full = drop_q;
	assign entry_count  = count_q;
	assign best_ms      = best_q;
	assign best_minutes = bmin_q;
	assign best_seconds = bsec_q;
	assign mean_ms      = mean_q;
	assign mean_minutes = mmin_q;
	assign mean_seconds = msec_q;
	assign second_ms    = second_q;
	assign third_ms     = third_q;

	a_strobe_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result beat outside a command");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !(accepted && dropped_full))
		else $error("time both inserted and dropped");

	a_idle_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !busy)
		else $error("sequencer did not return to idle after the result beat");

endmodule

### src/ltrt_div.sv
// Shared restoring divider: one quotient bit per cycle.
// Depends on ltrt_pkg (imported for house consistency of types).
module ltrt_div
	import ltrt_pkg::*;
#(
	parameter int DW = 30,
	parameter int VW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [VW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quot_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;

	logic [VW:0] trial;
	logic [VW:0] diff;
	logic        ge;

	assign trial = {rem_q, quot_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[DW-2:0], ge};
			rem_q  <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

	a_done_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !run_q)
		else $error("divider signals done while still iterating");

endmodule

### src/ltrt_insert.sv
// Sorted lap time table: memory, ordered insertion walk, count, sum, top three.
// Depends on ltrt_pkg for the time width, state type and status struct.
module ltrt_insert
	import ltrt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int CNT_W       = $clog2(TABLE_DEPTH + 1),
	parameter int SUM_W       = TIME_W + $clog2(TABLE_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] lap_ms,
	output ins_stat_t         stat,
	output logic [CNT_W-1:0]  count,
	output logic [SUM_W-1:0]  sum,
	output logic [TIME_W-1:0] rank0,
	output logic [TIME_W-1:0] rank1,
	output logic [TIME_W-1:0] rank2
);

	localparam int AW = $clog2(TABLE_DEPTH);

	ins_state_t state_q, state_d;

	logic [TIME_W-1:0] mem [TABLE_DEPTH];
	logic [TIME_W-1:0] rd_data_q;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [TIME_W-1:0] wr_data;

	logic [AW-1:0]     pos_q;
	logic [TIME_W-1:0] t_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [TIME_W-1:0] r0_q, r1_q, r2_q;
	logic              acc_q, drop_q;

	logic full;
	logic is_zero;
	logic shift_up;

	assign full     = count_q == CNT_W'(TABLE_DEPTH);
	assign is_zero  = lap_ms == '0;
	assign shift_up = rd_data_q > t_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			I_IDLE: begin
				if (start) begin
					if (is_zero || full)
						state_d = I_DONE;
					else if (count_q == '0)
						state_d = I_WRITE;
					else
						state_d = I_READ;
				end
			end
			I_READ:  state_d = I_CMP;
			I_CMP: begin
				if (shift_up && pos_q != AW'(1))
					state_d = I_READ;
				else
					state_d = I_WRITE;
			end
			I_WRITE: state_d = I_DONE;
			I_DONE:  state_d = I_IDLE;
			default: state_d = I_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_q - 1'b1;
		wr_en   = 1'b0;
		wr_addr = pos_q;
		wr_data = t_q;
		case (state_q)
			I_READ:  rd_en = 1'b1;
			I_CMP: begin
				wr_en   = shift_up;
				wr_data = rd_data_q;
			end
			I_WRITE: wr_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= I_IDLE;
			count_q <= '0;
			sum_q   <= '0;
			r0_q    <= '0;
			r1_q    <= '0;
			r2_q    <= '0;
			acc_q   <= 1'b0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == I_IDLE && start) begin
				acc_q  <= !is_zero && !full;
				drop_q <= !is_zero && full;
			end
			if (state_q == I_WRITE) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(t_q);
				if ({1'b0, pos_q} == (AW+1)'(0)) begin
					r2_q <= r1_q;
					r1_q <= r0_q;
					r0_q <= t_q;
				end else if ({1'b0, pos_q} == (AW+1)'(1)) begin
					r2_q <= r1_q;
					r1_q <= t_q;
				end else if ({1'b0, pos_q} == (AW+1)'(2)) begin
					r2_q <= t_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == I_IDLE && start) begin
			t_q   <= lap_ms;
			pos_q <= count_q[AW-1:0];
		end else if (state_q == I_CMP && shift_up) begin
			pos_q <= pos_q - 1'b1;
		end
	end

	assign stat.done     = state_q == I_DONE;
	assign stat.accepted = acc_q;
	assign stat.dropped  = drop_q;
	assign count         = count_q;
	assign sum           = sum_q;
	assign rank0         = r0_q;
	assign rank1         = r1_q;
	assign rank2         = r2_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_rank_order_01: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2) && state_q == I_IDLE) |-> r0_q <= r1_q)
		else $error("best and second times out of order");

	a_rank_order_12: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(3) && state_q == I_IDLE) |-> r1_q <= r2_q)
		else $error("second and third times out of order");

endmodule

### tb/sv/lap_time_ranking_table_core_test.sv
// Self-checking testbench for lap_time_ranking_table_core: sends lap times over the command
// port, predicts the ranking table in SystemVerilog and checks each result beat.
// Depends on ltrt_pkg and the lap_time_ranking_table_core RTL.
module lap_time_ranking_table_core_test;
	import ltrt_pkg::*;

	// Safety net: about 675 commands, plus sender gaps, stay well below this.
	localparam int CYCLE_LIMIT     = 1500000;
	localparam int RANDOM_COMMANDS = 650;
	localparam int PHASE_LEN       = 50;
	localparam int SETTLE_CYCLES   = 300;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	// One expected result beat.
	typedef struct {
		logic                 accepted;
		logic                 dropped;
		logic [CNT_OUT_W-1:0] count;
		logic [TIME_W-1:0]    best;
		logic [MIN_W-1:0]     best_min;
		logic [SEC_W-1:0]     best_sec;
		logic [TIME_W-1:0]    mean;
		logic [MIN_W-1:0]     mean_min;
		logic [SEC_W-1:0]     mean_sec;
		logic [TIME_W-1:0]    second;
		logic [TIME_W-1:0]    third;
	} lap_standing_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [TIME_W-1:0]    lap_ms = '0;
	logic                 busy;
	logic                 strobe;
	logic                 accepted;
	logic                 dropped_full;
	logic [CNT_OUT_W-1:0] entry_count;
	logic [TIME_W-1:0]    best_ms;
	logic [MIN_W-1:0]     best_minutes;
	logic [SEC_W-1:0]     best_seconds;
	logic [TIME_W-1:0]    mean_ms;
	logic [MIN_W-1:0]     mean_minutes;
	logic [SEC_W-1:0]     mean_seconds;
	logic [TIME_W-1:0]    second_ms;
	logic [TIME_W-1:0]    third_ms;

	// Shadow of the ranking table: stored times in ascending order and their sum.
	logic [TIME_W-1:0] ranked_laps[$];
	longint unsigned   lap_total = 0;

	// Standings predicted for every sent command, oldest first.
	lap_standing_t awaited_standings[$];
	lap_standing_t head_standing;

	int error_count = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int random_sent = 0;

	lap_time_ranking_table_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.lap_ms       (lap_ms),
		.busy         (busy),
		.strobe       (strobe),
		.accepted     (accepted),
		.dropped_full (dropped_full),
		.entry_count  (entry_count),
		.best_ms      (best_ms),
		.best_minutes (best_minutes),
		.best_seconds (best_seconds),
		.mean_ms      (mean_ms),
		.mean_minutes (mean_minutes),
		.mean_seconds (mean_seconds),
		.second_ms    (second_ms),
		.third_ms     (third_ms)
	);

	always #5 clk = ~clk;

	// Abort a hung run; the fail line is the only output.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Apply one lap time to the shadow table and return the standings it yields.
	// A nonzero time goes in after any equal ones; a full table drops it; zero is a query.
	function automatic lap_standing_t rank_lap(input logic [TIME_W-1:0] lap);
		lap_standing_t s;
		int            slot;
		logic [TIME_W-1:0] mean_val;
		s = '{default: '0};
		if (lap != '0) begin
			if (ranked_laps.size() < TABLE_DEPTH_DEF) begin
				slot = 0;
				while (slot < ranked_laps.size() && ranked_laps[slot] <= lap)
					slot++;
				ranked_laps.insert(slot, lap);
				lap_total += 64'(lap);
				s.accepted = 1'b1;
			end else begin
				s.dropped = 1'b1;
			end
		end
		s.count = CNT_OUT_W'(ranked_laps.size());
		mean_val = '0;
		if (ranked_laps.size() != 0) begin
			s.best   = ranked_laps[0];
			mean_val = TIME_W'(lap_total / ranked_laps.size());
		end
		if (ranked_laps.size() > 1)
			s.second = ranked_laps[1];
		if (ranked_laps.size() > 2)
			s.third = ranked_laps[2];
		s.mean     = mean_val;
		s.best_min = MIN_W'(s.best / MS_PER_MINUTE);
		s.best_sec = SEC_W'((s.best % MS_PER_MINUTE) / MS_PER_SECOND);
		s.mean_min = MIN_W'(s.mean / MS_PER_MINUTE);
		s.mean_sec = SEC_W'((s.mean % MS_PER_MINUTE) / MS_PER_SECOND);
		return s;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Result monitor: the receiver cannot stall, so take every strobe beat at its edge
	// and match it against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (awaited_standings.size() == 0) begin
				$error("result beat with no command outstanding");
				error_count++;
			end else begin
				head_standing = awaited_standings.pop_front();
				check_field("accepted",     32'(head_standing.accepted), 32'(accepted));
				check_field("dropped_full", 32'(head_standing.dropped),  32'(dropped_full));
				check_field("entry_count",  32'(head_standing.count),    32'(entry_count));
				check_field("best_ms",      32'(head_standing.best),     32'(best_ms));
				check_field("best_minutes", 32'(head_standing.best_min), 32'(best_minutes));
				check_field("best_seconds", 32'(head_standing.best_sec), 32'(best_seconds));
				check_field("mean_ms",      32'(head_standing.mean),     32'(mean_ms));
				check_field("mean_minutes", 32'(head_standing.mean_min), 32'(mean_minutes));
				check_field("mean_seconds", 32'(head_standing.mean_sec), 32'(mean_seconds));
				check_field("second_ms",    32'(head_standing.second),   32'(second_ms));
				check_field("third_ms",     32'(head_standing.third),    32'(third_ms));
			end
		end
	end

	// Send one lap time. Start stays high after the beat so that back-to-back commands
	// need no second assignment in one step; only an idle gap lowers it.
	task automatic send_lap(input logic [TIME_W-1:0] lap);
		if ($urandom_range(99) < idle_pct) begin
			start  <= 1'b0;
			lap_ms <= TIME_W'($urandom);
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		start  <= 1'b1;
		lap_ms <= lap;
		// Wait for the edge that takes the beat: start high and busy low.
		do
			@(posedge clk);
		while (busy !== 1'b0);
		awaited_standings.push_back(rank_lap(lap));
	endtask

	// Drop start and hold off until every predicted result has come back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (awaited_standings.size() != 0)
			@(posedge clk);
	endtask

	// Rotate the sender gap rate: none, heavy, light.
	task automatic next_idle_phase();
		case (idle_pct)
			0:       idle_pct = 55;
			55:      idle_pct = 17;
			default: idle_pct = 0;
		endcase
	endtask

	// Lap time near a minute or second boundary, clipped to the field.
	function automatic logic [TIME_W-1:0] boundary_lap();
		int v;
		v = int'($urandom_range(279) * MS_PER_MINUTE + $urandom_range(59) * MS_PER_SECOND);
		case ($urandom_range(2))
			0:       v = v + 999;
			1:       v = v + 1;
			default: v = v;
		endcase
		if (v > int'(TIME_MAX))
			v = int'(TIME_MAX);
		return TIME_W'(v);
	endfunction

	// Queries on the empty table: everything reads zero.
	task automatic test_empty_table();
		idle_pct = 0;
		send_lap('0);
		send_lap('0);
	endtask

	// Field extremes, equal times, minute and second edges, unfilled ranks.
	task automatic test_extremes();
		idle_pct = 17;
		send_lap(TIME_MAX);
		send_lap('0);
		send_lap(24'd1);
		send_lap(24'd1);
		send_lap(24'h800000);
		send_lap(24'd59999);
		send_lap(24'd60000);
		send_lap(24'h555555);
		send_lap(24'hAAAAAA);
		send_lap(24'd999);
		send_lap(24'd1000);
		drain_results();
	endtask

	// Random commands until the table is full: mixed magnitudes, repeats of stored
	// times and boundary values, with queries sprinkled in.
	task automatic test_random_fill();
		logic [TIME_W-1:0] lap;
		int                pick;
		while (ranked_laps.size() < TABLE_DEPTH_DEF) begin
			pick = $urandom_range(99);
			if (pick < 20)
				lap = '0;
			else if (pick < 40 && ranked_laps.size() != 0)
				lap = ranked_laps[$urandom_range(ranked_laps.size() - 1)];
			else if (pick < 60)
				lap = boundary_lap();
			else
				lap = TIME_W'(($urandom & TIME_MAX) >> $urandom_range(TIME_W - 1));
			send_lap(lap);
			random_sent++;
			if (random_sent % PHASE_LEN == 0) begin
				drain_results();
				next_idle_phase();
			end
		end
	endtask

	// Table full: every nonzero time is dropped, queries still report.
	task automatic test_table_full();
		send_lap(TIME_MAX);
		send_lap(24'd1);
		send_lap('0);
		send_lap(24'h7FFFFF);
		drain_results();
	endtask

	// Random traffic on the full table until the random budget is spent.
	task automatic test_random_overflow();
		logic [TIME_W-1:0] lap;
		while (random_sent < RANDOM_COMMANDS) begin
			if ($urandom_range(1) == 0)
				lap = '0;
			else
				lap = TIME_W'($urandom);
			send_lap(lap);
			random_sent++;
			if (random_sent % PHASE_LEN == 0) begin
				drain_results();
				next_idle_phase();
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_extremes();
		test_random_fill();
		test_table_full();
		test_random_overflow();
		drain_results();
		// Let a stray late beat show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
src/ltrt_pkg.sv
src/ltrt_div.sv
src/ltrt_insert.sv
src/lap_time_ranking_table_core.sv
tb/sv/lap_time_ranking_table_core_test.sv
